// ===== rtl/rmq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rmq_pkg;

    localparam int IN_W          = 18;
    localparam int IN_FRAC_BITS  = 14;
    localparam int OUT_FRAC_BITS = 14;
    localparam int OUT_W         = 16;
    localparam int QW            = 20;  // signed width of an unnormalized component
    localparam int MAGW          = 19;  // magnitude of an unnormalized component
    localparam int NORM_W        = 30;  // width of normalized magnitudes; the largest nonzero one lies in [2^29, 2^30)
    localparam int NORM_MSB      = 29;
    localparam int SH_W          = 5;
    localparam int SQ_W          = 60;
    localparam int RAD_W         = 62;
    localparam int ROOT_W        = 31;
    localparam int REM_W         = 34;
    localparam int SQ_STEPS      = 31;
    localparam int QUO_W         = 15;
    localparam int NUM_W         = 45;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = 2;
    localparam int FIFO_CW       = 3;

    localparam logic signed [QW-1:0] UNIT_RAW      = QW'(2 ** IN_FRAC_BITS);
    localparam logic signed [QW-1:0] TRACE_EPS_RAW = QW'((2 ** IN_FRAC_BITS) / 100000);
    localparam logic [QUO_W-1:0]     OUT_LIMIT     = QUO_W'(2 ** OUT_FRAC_BITS);

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } branch_t;

    // One classified request as it travels from the front end to the back end.
    typedef struct packed {
        logic [3:0]            neg;
        logic [3:0][MAGW-1:0]  mag;
        branch_t               branch;
        logic                  degen;
    } rmq_item_t;

    // Sideband that rides along the back-end pipeline.
    typedef struct packed {
        logic [3:0] neg;
        branch_t    branch;
        logic       degen;
    } rmq_side_t;

endpackage

`default_nettype wire

// ===== rtl/rmq_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rmq_front (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [8:0][rmq_pkg::IN_W-1:0]     rot,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output rmq_pkg::rmq_item_t                     out_item
);
    import rmq_pkg::*;

    logic signed [QW-1:0] r [9];
    logic signed [QW-1:0] t, d, q [4];
    rmq_item_t item;
    logic valid_reg;
    rmq_item_t item_reg;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            r[i] = {{(QW - IN_W){rot[i][IN_W-1]}}, rot[i]};
        end
        t = r[0] + r[4] + r[8] + UNIT_RAW;
        item.branch = BR_TRACE;
        d = '0;
        if (t > TRACE_EPS_RAW) begin
            q[0] = r[7] - r[5]; q[1] = r[2] - r[6]; q[2] = r[3] - r[1]; q[3] = t;
        end else if (r[0] > r[4] && r[0] > r[8]) begin
            item.branch = BR_X;
            d = UNIT_RAW + r[0] - r[4] - r[8];
            q[0] = d; q[1] = r[1] + r[3]; q[2] = r[2] + r[6]; q[3] = r[7] - r[5];
        end else if (r[4] > r[8]) begin
            item.branch = BR_Y;
            d = UNIT_RAW + r[4] - r[0] - r[8];
            q[0] = r[1] + r[3]; q[1] = d; q[2] = r[5] + r[7]; q[3] = r[2] - r[6];
        end else begin
            item.branch = BR_Z;
            d = UNIT_RAW + r[8] - r[0] - r[4];
            q[0] = r[2] + r[6]; q[1] = r[5] + r[7]; q[2] = d; q[3] = r[3] - r[1];
        end
        for (int i = 0; i < 4; i++) begin
            item.neg[i] = q[i][QW-1];
            item.mag[i] = item.neg[i] ? MAGW'(-q[i]) : MAGW'(q[i]);
        end
        item.degen = ((item.branch != BR_TRACE) && (d <= 0)) ||
                     ((item.mag[0] | item.mag[1] | item.mag[2] | item.mag[3]) == '0);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rmq_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rmq_fifo (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire rmq_pkg::rmq_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output rmq_pkg::rmq_item_t       out_item
);
    import rmq_pkg::*;

    rmq_item_t             slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0]    count_reg, count_next;
    logic                  push, pop;

    assign in_ready  = (count_reg != FIFO_CW'(FIFO_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    // The fill count must agree with the distance between the pointers.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == FIFO_CW'(FIFO_DEPTH)) ||
        (FIFO_AW'(count_reg) == FIFO_AW'(wr_ptr_reg - rd_ptr_reg)))
        else $error("fifo count and pointers disagree");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("fifo overfilled");

endmodule

`default_nettype wire

// ===== rtl/rmq_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rmq_back (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire rmq_pkg::rmq_item_t       in_item,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [rmq_pkg::OUT_W-1:0]     quat_x,
    output logic [rmq_pkg::OUT_W-1:0]     quat_y,
    output logic [rmq_pkg::OUT_W-1:0]     quat_z,
    output logic [rmq_pkg::OUT_W-1:0]     quat_w,
    output logic [1:0]                    branch_used,
    output logic                          degenerate
);
    import rmq_pkg::*;

    logic ce;

    // Stage A: leading-one detection on the OR of the magnitudes.
    logic [MAGW-1:0]   any_mag;
    logic [SH_W-1:0]   sh;
    logic              a_valid_reg;
    rmq_item_t         a_item_reg;
    logic [SH_W-1:0]   a_sh_reg;

    // Stage B: normalized magnitudes. Stage C: squares. D, E: sum.
    logic              b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg;
    rmq_side_t         b_side_reg, c_side_reg, d_side_reg, e_side_reg;
    logic [NORM_W-1:0] b_mag_reg [4];
    logic [NORM_W-1:0] c_mag_reg [4];
    logic [NORM_W-1:0] d_mag_reg [4];
    logic [NORM_W-1:0] e_mag_reg [4];
    logic [SQ_W-1:0]   c_sq_reg [4];
    logic [SQ_W:0]     d_sum_reg [2];
    logic [RAD_W-1:0]  e_sum_reg;

    // Square-root pipeline, one result bit per stage.
    logic              s_valid_reg [SQ_STEPS];
    rmq_side_t         s_side_reg  [SQ_STEPS];
    logic [NORM_W-1:0] s_mag_reg   [SQ_STEPS][4];
    logic [RAD_W-1:0]  s_rad_reg   [SQ_STEPS];
    logic [REM_W-1:0]  s_rem_reg   [SQ_STEPS];
    logic [ROOT_W-1:0] s_root_reg  [SQ_STEPS];
    logic [RAD_W-1:0]  s_rad_next  [SQ_STEPS];
    logic [REM_W-1:0]  s_rem_next  [SQ_STEPS];
    logic [ROOT_W-1:0] s_root_next [SQ_STEPS];

    // Division pipeline, four lanes, one quotient bit per stage.
    logic              v_valid_reg [QUO_W+1];
    rmq_side_t         v_side_reg  [QUO_W+1];
    logic [ROOT_W-1:0] v_div_reg   [QUO_W+1];
    logic [ROOT_W-1:0] v_rem_reg   [QUO_W+1][4];
    logic [QUO_W-1:0]  v_low_reg   [QUO_W+1][4];
    logic [QUO_W-1:0]  v_quo_reg   [QUO_W+1][4];
    logic [ROOT_W-1:0] v_rem_next  [QUO_W+1][4];
    logic [QUO_W-1:0]  v_low_next  [QUO_W+1][4];
    logic [QUO_W-1:0]  v_quo_next  [QUO_W+1][4];
    logic [NUM_W-1:0]  num [4];

    logic              out_valid_reg;
    logic [OUT_W-1:0]  quat_reg [4];
    logic [OUT_W-1:0]  quat_next [4];
    branch_t           branch_reg;
    logic              degen_reg;

    assign ce       = !out_valid_reg || out_ready;
    assign in_ready = ce;

    always_comb begin
        any_mag = in_item.mag[0] | in_item.mag[1] | in_item.mag[2] | in_item.mag[3];
        sh = SH_W'(NORM_MSB);
        for (int i = 0; i < MAGW; i++) begin
            if (any_mag[i]) begin
                sh = SH_W'(NORM_MSB - i);
            end
        end
    end

    // Square-root steps.
    always_comb begin
        for (int k = 0; k < SQ_STEPS; k++) begin
            logic [RAD_W-1:0]  rad;
            logic [REM_W-1:0]  rem, cur, trial;
            logic [ROOT_W-1:0] root;
            rad  = (k == 0) ? e_sum_reg : s_rad_reg[(k == 0) ? 0 : k - 1];
            rem  = (k == 0) ? '0 : s_rem_reg[(k == 0) ? 0 : k - 1];
            root = (k == 0) ? '0 : s_root_reg[(k == 0) ? 0 : k - 1];
            cur   = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
            trial = {1'b0, root, 2'b01};
            s_rad_next[k] = {rad[RAD_W-3:0], 2'b00};
            if (cur >= trial) begin
                s_rem_next[k]  = cur - trial;
                s_root_next[k] = {root[ROOT_W-2:0], 1'b1};
            end else begin
                s_rem_next[k]  = cur;
                s_root_next[k] = {root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Division setup (stage 0) and restoring steps.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            num[i] = {s_mag_reg[SQ_STEPS-1][i], {OUT_FRAC_BITS{1'b0}}, 1'b0} >> 1;
            num[i] = num[i] + NUM_W'(s_root_reg[SQ_STEPS-1] >> 1);
            v_rem_next[0][i] = ROOT_W'(num[i][NUM_W-1:QUO_W]);
            v_low_next[0][i] = num[i][QUO_W-1:0];
            v_quo_next[0][i] = '0;
        end
        for (int k = 1; k <= QUO_W; k++) begin
            for (int i = 0; i < 4; i++) begin
                logic [ROOT_W:0] cur;
                cur = {v_rem_reg[k-1][i], v_low_reg[k-1][i][QUO_W-1]};
                v_low_next[k][i] = {v_low_reg[k-1][i][QUO_W-2:0], 1'b0};
                if (cur >= {1'b0, v_div_reg[k-1]}) begin
                    v_rem_next[k][i] = ROOT_W'(cur - {1'b0, v_div_reg[k-1]});
                    v_quo_next[k][i] = {v_quo_reg[k-1][i][QUO_W-2:0], 1'b1};
                end else begin
                    v_rem_next[k][i] = ROOT_W'(cur);
                    v_quo_next[k][i] = {v_quo_reg[k-1][i][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    // Clamp, sign, and zeroing of degenerate requests.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            logic [QUO_W-1:0] n;
            n = (v_quo_reg[QUO_W][i] > OUT_LIMIT) ? OUT_LIMIT : v_quo_reg[QUO_W][i];
            if (v_side_reg[QUO_W].degen) begin
                quat_next[i] = '0;
            end else if (v_side_reg[QUO_W].neg[i]) begin
                quat_next[i] = OUT_W'(0) - OUT_W'(n);
            end else begin
                quat_next[i] = OUT_W'(n);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < SQ_STEPS; k++) begin
                s_valid_reg[k] <= 1'b0;
            end
            for (int k = 0; k <= QUO_W; k++) begin
                v_valid_reg[k] <= 1'b0;
            end
        end else if (ce) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            for (int k = 0; k < SQ_STEPS; k++) begin
                s_valid_reg[k] <= (k == 0) ? e_valid_reg : s_valid_reg[(k == 0) ? 0 : k - 1];
            end
            v_valid_reg[0] <= s_valid_reg[SQ_STEPS-1];
            for (int k = 1; k <= QUO_W; k++) begin
                v_valid_reg[k] <= v_valid_reg[k-1];
            end
            out_valid_reg <= v_valid_reg[QUO_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a_item_reg <= in_item;
            a_sh_reg   <= sh;

            b_side_reg <= '{neg: a_item_reg.neg, branch: a_item_reg.branch,
                            degen: a_item_reg.degen};
            c_side_reg <= b_side_reg;
            d_side_reg <= c_side_reg;
            e_side_reg <= d_side_reg;
            for (int i = 0; i < 4; i++) begin
                b_mag_reg[i] <= NORM_W'(a_item_reg.mag[i]) << a_sh_reg;
                c_mag_reg[i] <= b_mag_reg[i];
                c_sq_reg[i]  <= SQ_W'(b_mag_reg[i]) * SQ_W'(b_mag_reg[i]);
                d_mag_reg[i] <= c_mag_reg[i];
                e_mag_reg[i] <= d_mag_reg[i];
            end
            d_sum_reg[0] <= {1'b0, c_sq_reg[0]} + {1'b0, c_sq_reg[1]};
            d_sum_reg[1] <= {1'b0, c_sq_reg[2]} + {1'b0, c_sq_reg[3]};
            e_sum_reg    <= {1'b0, d_sum_reg[0]} + {1'b0, d_sum_reg[1]};

            for (int k = 0; k < SQ_STEPS; k++) begin
                s_side_reg[k] <= (k == 0) ? e_side_reg : s_side_reg[(k == 0) ? 0 : k - 1];
                for (int i = 0; i < 4; i++) begin
                    s_mag_reg[k][i] <= (k == 0) ? e_mag_reg[i]
                                                : s_mag_reg[(k == 0) ? 0 : k - 1][i];
                end
                s_rad_reg[k]  <= s_rad_next[k];
                s_rem_reg[k]  <= s_rem_next[k];
                s_root_reg[k] <= s_root_next[k];
            end

            v_side_reg[0] <= s_side_reg[SQ_STEPS-1];
            v_div_reg[0]  <= s_root_reg[SQ_STEPS-1];
            for (int k = 1; k <= QUO_W; k++) begin
                v_side_reg[k] <= v_side_reg[k-1];
                v_div_reg[k]  <= v_div_reg[k-1];
            end
            for (int k = 0; k <= QUO_W; k++) begin
                for (int i = 0; i < 4; i++) begin
                    v_rem_reg[k][i] <= v_rem_next[k][i];
                    v_low_reg[k][i] <= v_low_next[k][i];
                    v_quo_reg[k][i] <= v_quo_next[k][i];
                end
            end

            for (int i = 0; i < 4; i++) begin
                quat_reg[i] <= quat_next[i];
            end
            branch_reg <= v_side_reg[QUO_W].branch;
            degen_reg  <= v_side_reg[QUO_W].degen;
        end
    end

    assign out_valid   = out_valid_reg;
    assign quat_x      = quat_reg[0];
    assign quat_y      = quat_reg[1];
    assign quat_z      = quat_reg[2];
    assign quat_w      = quat_reg[3];
    assign branch_used = branch_reg;
    assign degenerate  = degen_reg;

    // A degenerate result carries all-zero components.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && degen_reg |->
            (quat_reg[0] == '0) && (quat_reg[1] == '0) &&
            (quat_reg[2] == '0) && (quat_reg[3] == '0))
        else $error("degenerate result with nonzero components");

    // A valid, non-degenerate request enters the root pipeline normalized.
    assert property (@(posedge aclk) disable iff (!aresetn)
        e_valid_reg && !e_side_reg.degen |->
            (e_mag_reg[0][NORM_MSB] || e_mag_reg[1][NORM_MSB] ||
             e_mag_reg[2][NORM_MSB] || e_mag_reg[3][NORM_MSB]))
        else $error("magnitudes not normalized");

    // A held result stays put while the pipeline is frozen.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(quat_reg[0]) &&
            $stable(quat_reg[3]) && $stable(branch_reg))
        else $error("pipeline advanced under back-pressure");

endmodule

`default_nettype wire

// ===== rtl/rotation_matrix_to_quaternion_top.sv =====
//  Channel   Direction  Handshake           Payload
//  s_        in         s_valid / s_ready   s_rot_r0_c0 .. s_rot_r2_c2 (18-bit signed Q3.14)
//  m_        out        m_valid / m_ready   m_quat_x/y/z/w (16-bit Q1.14), m_branch_used,
//                                           m_degenerate
//
//  One request is accepted per cycle and one result leaves per cycle while m_ready is high.
//  A request passes the front register, the queue, then 53 back-end
//  stages, of which 31 form the square root and 16 the four-lane divider.
//  aresetn is synchronous and active low; it empties every stage and the queue.
//  A stall on m_ready freezes the back end; the four-entry queue and the front
//  register keep s_ready high until they fill.
`timescale 1ns / 1ps
`default_nettype none

module rotation_matrix_to_quaternion_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [rmq_pkg::IN_W-1:0]       s_rot_r0_c0,
    input  wire logic [rmq_pkg::IN_W-1:0]       s_rot_r0_c1,
    input  wire logic [rmq_pkg::IN_W-1:0]       s_rot_r0_c2,
    input  wire logic [rmq_pkg::IN_W-1:0]       s_rot_r1_c0,
    input  wire logic [rmq_pkg::IN_W-1:0]       s_rot_r1_c1,
    input  wire logic [rmq_pkg::IN_W-1:0]       s_rot_r1_c2,
    input  wire logic [rmq_pkg::IN_W-1:0]       s_rot_r2_c0,
    input  wire logic [rmq_pkg::IN_W-1:0]       s_rot_r2_c1,
    input  wire logic [rmq_pkg::IN_W-1:0]       s_rot_r2_c2,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [rmq_pkg::OUT_W-1:0]           m_quat_x,
    output logic [rmq_pkg::OUT_W-1:0]           m_quat_y,
    output logic [rmq_pkg::OUT_W-1:0]           m_quat_z,
    output logic [rmq_pkg::OUT_W-1:0]           m_quat_w,
    output logic [1:0]                          m_branch_used,
    output logic                                m_degenerate
);
    import rmq_pkg::*;

    logic [8:0][IN_W-1:0] rot;
    logic      front_valid, front_ready;
    rmq_item_t front_item;
    logic      queue_valid, queue_ready;
    rmq_item_t queue_item;

    // Elements in row-major order, row 0 column 0 in slot 0.
    assign rot = {s_rot_r2_c2, s_rot_r2_c1, s_rot_r2_c0,
                  s_rot_r1_c2, s_rot_r1_c1, s_rot_r1_c0,
                  s_rot_r0_c2, s_rot_r0_c1, s_rot_r0_c0};

    // The front end picks the branch and forms the unnormalized quaternion.
    rmq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .rot       (rot),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    // The queue decouples the front end from back-end stalls.
    rmq_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_item  (queue_item)
    );

    // The back end normalizes: sum of squares, square root, and division.
    rmq_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (queue_valid),
        .in_ready    (queue_ready),
        .in_item     (queue_item),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .quat_x      (m_quat_x),
        .quat_y      (m_quat_y),
        .quat_z      (m_quat_z),
        .quat_w      (m_quat_w),
        .branch_used (m_branch_used),
        .degenerate  (m_degenerate)
    );

endmodule

`default_nettype wire

// ===== dv/rotation_matrix_to_quaternion_top_test.sv =====
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_top_test;
    import rmq_pkg::*;

    // One matrix request: nine signed Q3.14 elements, row major.
    typedef struct {
        logic signed [IN_W-1:0] e [9];
    } matrix_t;

    // One quaternion result as the block should report it.
    typedef struct {
        logic [OUT_W-1:0] qx, qy, qz, qw;
        branch_t          branch;
        logic             degen;
    } quat_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [IN_W-1:0] s_el [9];
    logic m_valid;
    logic m_ready = 1'b0;
    logic [OUT_W-1:0] m_quat_x, m_quat_y, m_quat_z, m_quat_w;
    logic [1:0] m_branch_used;
    logic m_degenerate;

    matrix_t pending_matrices [$];
    quat_t   expected_quats [$];
    int      errors = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    bit      hold_sender = 1'b0;
    bit      in_taken = 1'b0;
    int      quiet_cycles = 0;

    initial begin
        for (int i = 0; i < 9; i++) s_el[i] = '0;
    end

    always #4 aclk = ~aclk;

    rotation_matrix_to_quaternion_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_rot_r0_c0(s_el[0]), .s_rot_r0_c1(s_el[1]), .s_rot_r0_c2(s_el[2]),
        .s_rot_r1_c0(s_el[3]), .s_rot_r1_c1(s_el[4]), .s_rot_r1_c2(s_el[5]),
        .s_rot_r2_c0(s_el[6]), .s_rot_r2_c1(s_el[7]), .s_rot_r2_c2(s_el[8]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_quat_x(m_quat_x), .m_quat_y(m_quat_y), .m_quat_z(m_quat_z),
        .m_quat_w(m_quat_w), .m_branch_used(m_branch_used), .m_degenerate(m_degenerate)
    );

    // Bitwise integer square root, floor.
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Shepperd conversion: pick the branch, build the scaled quaternion,
    // then normalize it in fixed point with rounding and clamping.
    function automatic quat_t quat_from_matrix(matrix_t m);
        quat_t r;
        longint q [4];
        longint unsigned mag [4];
        bit neg [4];
        longint unsigned biggest, sum, root, n, res;
        longint unit, t, d, r00, r01, r02, r10, r11, r12, r20, r21, r22;
        int right, left;
        bit degen;
        unit = longint'(1) << IN_FRAC_BITS;
        r00 = m.e[0]; r01 = m.e[1]; r02 = m.e[2];
        r10 = m.e[3]; r11 = m.e[4]; r12 = m.e[5];
        r20 = m.e[6]; r21 = m.e[7]; r22 = m.e[8];
        degen = 1'b0;
        t = r00 + r11 + r22 + unit;
        if (t > unit / 100000) begin
            r.branch = BR_TRACE;
            q[0] = r21 - r12; q[1] = r02 - r20; q[2] = r10 - r01; q[3] = t;
        end else if (r00 > r11 && r00 > r22) begin
            d = unit + r00 - r11 - r22;
            r.branch = BR_X;
            degen = d <= 0;
            q[0] = d; q[1] = r01 + r10; q[2] = r02 + r20; q[3] = r21 - r12;
        end else if (r11 > r22) begin
            d = unit + r11 - r00 - r22;
            r.branch = BR_Y;
            degen = d <= 0;
            q[0] = r01 + r10; q[1] = d; q[2] = r12 + r21; q[3] = r02 - r20;
        end else begin
            d = unit + r22 - r00 - r11;
            r.branch = BR_Z;
            degen = d <= 0;
            q[0] = r02 + r20; q[1] = r12 + r21; q[2] = d; q[3] = r10 - r01;
        end
        biggest = 0;
        for (int i = 0; i < 4; i++) begin
            neg[i] = q[i] < 0;
            mag[i] = neg[i] ? longint'(-q[i]) : q[i];
            if (mag[i] > biggest) biggest = mag[i];
        end
        if (biggest == 0) degen = 1'b1;
        r.degen = degen;
        r.qx = '0; r.qy = '0; r.qz = '0; r.qw = '0;
        if (!degen) begin
            right = 0; left = 0;
            while (biggest >= (64'd1 << 30)) begin biggest >>= 1; right++; end
            while (biggest < (64'd1 << 29)) begin biggest <<= 1; left++; end
            sum = 0;
            for (int i = 0; i < 4; i++) begin
                mag[i] = (mag[i] >> right) << left;
                sum += mag[i] * mag[i];
            end
            root = int_sqrt(sum);
            for (int i = 0; i < 4; i++) begin
                n = ((mag[i] << OUT_FRAC_BITS) + (root >> 1)) / root;
                if (n > (64'd1 << OUT_FRAC_BITS)) n = 64'd1 << OUT_FRAC_BITS;
                if (n > 32767) n = 32767;
                res = neg[i] ? -n : n;
                case (i)
                    0: r.qx = res[OUT_W-1:0];
                    1: r.qy = res[OUT_W-1:0];
                    2: r.qz = res[OUT_W-1:0];
                    default: r.qw = res[OUT_W-1:0];
                endcase
            end
        end
        return r;
    endfunction

    // Driver: requests change at the falling edge and stay put until accepted.
    // The monitor marks an acceptance at the rising edge, since s_ready may
    // already have moved on by the falling edge.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                in_taken = 1'b0;
                if (pending_matrices.size() > 0 && !hold_sender
                        && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    for (int i = 0; i < 9; i++) s_el[i] <= pending_matrices[0].e[i];
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    // Monitor: predict on each accepted request and check each accepted result.
    always @(posedge aclk) begin
        matrix_t mt;
        quat_t want;
        bit moved;
        if (aresetn) begin
            moved = 1'b0;
            if (s_valid && s_ready) begin
                for (int i = 0; i < 9; i++) mt.e[i] = s_el[i];
                expected_quats.push_back(quat_from_matrix(mt));
                void'(pending_matrices.pop_front());
                in_taken = 1'b1;
                moved = 1'b1;
            end
            if (m_valid && m_ready) begin
                moved = 1'b1;
                if (expected_quats.size() == 0) begin
                    $error("result with no request outstanding");
                    errors++;
                end else begin
                    want = expected_quats.pop_front();
                    if (m_quat_x !== want.qx) begin
                        $error("quat_x expected %h actual %h", want.qx, m_quat_x); errors++;
                    end
                    if (m_quat_y !== want.qy) begin
                        $error("quat_y expected %h actual %h", want.qy, m_quat_y); errors++;
                    end
                    if (m_quat_z !== want.qz) begin
                        $error("quat_z expected %h actual %h", want.qz, m_quat_z); errors++;
                    end
                    if (m_quat_w !== want.qw) begin
                        $error("quat_w expected %h actual %h", want.qw, m_quat_w); errors++;
                    end
                    if (m_branch_used !== want.branch) begin
                        $error("branch_used expected %0d actual %0d", want.branch,
                               m_branch_used);
                        errors++;
                    end
                    if (m_degenerate !== want.degen) begin
                        $error("degenerate expected %b actual %b", want.degen, m_degenerate);
                        errors++;
                    end
                end
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("rotation_matrix_to_quaternion_top_test: FAIL");
                $finish;
            end
        end
    end

    function automatic matrix_t mat9(int a0, int a1, int a2, int a3, int a4,
                                     int a5, int a6, int a7, int a8);
        matrix_t m;
        m.e[0] = a0; m.e[1] = a1; m.e[2] = a2; m.e[3] = a3; m.e[4] = a4;
        m.e[5] = a5; m.e[6] = a6; m.e[7] = a7; m.e[8] = a8;
        return m;
    endfunction

    // A near-rotation: a chosen or random diagonal with random off-diagonals,
    // so that every branch, including the fallbacks, is reached often.
    function automatic matrix_t random_pose();
        matrix_t m;
        int kind, sp;
        kind = $urandom_range(5);
        sp = $urandom_range(1) ? 2000 : 16384;
        for (int i = 0; i < 9; i++) m.e[i] = $signed($urandom_range(2 * sp)) - sp;
        case (kind)
            0: begin m.e[0] = 16384; m.e[4] = 16384; m.e[8] = 16384; end
            1: begin m.e[0] = 16384; m.e[4] = -16384; m.e[8] = -16384; end
            2: begin m.e[0] = -16384; m.e[4] = 16384; m.e[8] = -16384; end
            3: begin m.e[0] = -16384; m.e[4] = -16384; m.e[8] = 16384; end
            4: begin m.e[0] = -16384 + $urandom_range(400); m.e[4] = m.e[0];
                     m.e[8] = m.e[0]; end
            default: ;
        endcase
        for (int i = 0; i < 9; i += 4)
            if (kind < 4) m.e[i] = m.e[i] + $signed($urandom_range(800)) - 400;
        return m;
    endfunction

    function automatic matrix_t random_noise();
        matrix_t m;
        for (int i = 0; i < 9; i++) m.e[i] = $urandom;
        return m;
    endfunction

    task automatic wait_drained();
        while (pending_matrices.size() > 0 || expected_quats.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        matrix_t m;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: identity, the three half-turns, all-zero, element extremes,
        // ties on the diagonal and non-positive fallback radicands.
        pending_matrices.push_back(mat9(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        pending_matrices.push_back(mat9(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
        pending_matrices.push_back(mat9(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
        pending_matrices.push_back(mat9(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
        pending_matrices.push_back(mat9(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_matrices.push_back(mat9(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
        pending_matrices.push_back(mat9(-131072, 0, 0, 0, -131072, 0, 0, 0, -131072));
        pending_matrices.push_back(mat9(131071, 131071, 131071, 131071, 131071,
                                        131071, 131071, 131071, 131071));
        pending_matrices.push_back(mat9(-131072, -131072, -131072, -131072, -131072,
                                        -131072, -131072, -131072, -131072));
        pending_matrices.push_back(mat9(-131072, 131071, -131072, 131071, -131072,
                                        131071, -131072, 131071, -131072));
        pending_matrices.push_back(mat9(-8192, 0, 0, 0, -8192, 0, 0, 0, -8192));
        pending_matrices.push_back(mat9(-30000, 5, 7, 9, -30000, 11, 13, 17, -30000));
        pending_matrices.push_back(mat9(-16384, 100, 0, 100, -16384, 0, 0, 0, 0));
        pending_matrices.push_back(mat9(-10000, 0, 0, 0, -40000, 0, 0, 0, -30000));
        pending_matrices.push_back(mat9(-40000, 0, 0, 0, -10000, 0, 0, 0, -30000));
        pending_matrices.push_back(mat9(0, 0, 0, 0, -16384, 0, 0, 0, -16384));
        pending_matrices.push_back(mat9(-16384, 3, 5, 7, -16384, 0, 0, 9, -16384 + 1));
        pending_matrices.push_back(mat9(-16385, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_matrices.push_back(mat9(1, 2, 3, 4, 5, 6, 7, 8, 9));

        // The test waits here until every directed result has come back.
        hold_sender = 1'b0;
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 20; recv_idle_pct = 71; end
                1: begin send_idle_pct = 71; recv_idle_pct = 20; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int k = 0; k < 500; k++) begin
                m = ($urandom_range(9) < 8) ? random_pose() : random_noise();
                pending_matrices.push_back(m);
                if (phase == 0 && k == 250) begin
                    while (pending_matrices.size() > 0) @(posedge aclk);
                    hold_sender = 1'b1;
                    while (expected_quats.size() > 0) @(posedge aclk);
                    hold_sender = 1'b0;
                end
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("rotation_matrix_to_quaternion_top_test: PASS");
        end else begin
            $display("rotation_matrix_to_quaternion_top_test: FAIL");
        end
        $finish;
    end
endmodule
